// ===== hdl/sls_amf_pkg.sv =====
// Types, constants and helper functions shared by the modulus factor pipeline.
package sls_amf_pkg;

  localparam int TERMS    = 5;
  localparam int YQ_STEPS = 27;
  localparam int RQ_STEPS = 32;

  typedef struct packed {
    logic [22:0] frequency;
    logic [23:0] quality_factor;
  } in_t;

  typedef struct packed {
    logic signed [31:0] factor_real;
    logic signed [31:0] factor_imag;
  } out_t;

  localparam logic [23:0] Q_MIN     = 24'd256;
  localparam logic [26:0] DEN_SCALE = 27'd100000000;
  localparam logic [35:0] OM_SCALE  = 36'd62831853072;

  localparam logic [19:0] WEIGHT_NUM [TERMS] = '{
    20'd969880, 20'd832481, 20'd887440, 20'd735887, 20'd866749
  };

  localparam logic [43:0] RATE [TERMS] = '{
    44'd471238898, 44'd6633708850, 44'd94247779600,
    44'd1146724360000, 44'd10559707900000
  };

  // Weight quotient cell payload: five divisions share one divisor.
  typedef struct packed {
    logic [50:0]                 den;
    logic [TERMS-1:0][50:0]      rem;
    logic [TERMS-1:0][26:0]      low;
    logic [TERMS-1:0][26:0]      quo;
    logic [42:0]                 om;
  } ydiv_t;

  // Corrector stage payload.
  typedef struct packed {
    logic [TERMS-1:0][26:0]      y;
    logic [TERMS-1:0][33:0]      d;
    logic [60:0]                 prod;
    logic [42:0]                 om;
  } corr_t;

  typedef struct packed {
    logic [TERMS-1:0][27:0]      a;
    logic [42:0]                 om;
  } wt_t;

  // Ratio cell payload: real and imaginary quotients for every term.
  typedef struct packed {
    logic [TERMS-1:0][62:0]      den;
    logic [TERMS-1:0][62:0]      rem_re;
    logic [TERMS-1:0][62:0]      rem_im;
    logic [TERMS-1:0][32:0]      q_re;
    logic [TERMS-1:0][32:0]      q_im;
    logic [TERMS-1:0][27:0]      a;
  } rdiv_t;

  function automatic logic [26:0] half27(input logic [26:0] v);
    logic [27:0] s;
    s = {1'b0, v} + 28'd1;
    return s[27:1];
  endfunction

  // Smallest right shift that brings m below 2^31.
  function automatic logic [3:0] norm_shift(input logic [43:0] m);
    logic [3:0] s;
    s = '0;
    for (int b = 31; b < 44; b++) begin
      if (m[b]) s = 4'(b - 30);
    end
    return s;
  endfunction

endpackage

// ===== hdl/sls_amf_ydiv_cell.sv =====
// One restoring quotient bit for the five scaled weight divisions.
module sls_amf_ydiv_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  sls_amf_pkg::ydiv_t  din,
  output logic                out_valid,
  output sls_amf_pkg::ydiv_t  dout
);

  sls_amf_pkg::ydiv_t step;

  always_comb begin
    logic [51:0] t;
    step = din;
    for (int i = 0; i < sls_amf_pkg::TERMS; i++) begin
      t = {din.rem[i], din.low[i][26]};
      if (t >= {1'b0, din.den}) begin
        step.rem[i] = 51'(t - {1'b0, din.den});
        step.quo[i] = {din.quo[i][25:0], 1'b1};
      end else begin
        step.rem[i] = t[50:0];
        step.quo[i] = {din.quo[i][25:0], 1'b0};
      end
      step.low[i] = {din.low[i][25:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dout <= step;
  end

endmodule

// ===== hdl/sls_amf_rdiv_cell.sv =====
// One restoring quotient bit for the ten response ratio divisions.
module sls_amf_rdiv_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  sls_amf_pkg::rdiv_t  din,
  output logic                out_valid,
  output sls_amf_pkg::rdiv_t  dout
);

  sls_amf_pkg::rdiv_t step;

  always_comb begin
    logic [63:0] tr;
    logic [63:0] ti;
    step = din;
    for (int i = 0; i < sls_amf_pkg::TERMS; i++) begin
      tr = {din.rem_re[i], 1'b0};
      ti = {din.rem_im[i], 1'b0};
      if (tr >= {1'b0, din.den[i]}) begin
        step.rem_re[i] = 63'(tr - {1'b0, din.den[i]});
        step.q_re[i]   = {din.q_re[i][31:0], 1'b1};
      end else begin
        step.rem_re[i] = tr[62:0];
        step.q_re[i]   = {din.q_re[i][31:0], 1'b0};
      end
      if (ti >= {1'b0, din.den[i]}) begin
        step.rem_im[i] = 63'(ti - {1'b0, din.den[i]});
        step.q_im[i]   = {din.q_im[i][31:0], 1'b1};
      end else begin
        step.rem_im[i] = ti[62:0];
        step.q_im[i]   = {din.q_im[i][31:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dout <= step;
  end

endmodule

// ===== hdl/sls_amf_corr.sv =====
// Corrector recurrence over the scaled weights and the final weight products.
module sls_amf_corr (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  logic [sls_amf_pkg::TERMS-1:0][26:0]          y,
  input  logic [42:0]                                  om,
  output logic                                         out_valid,
  output sls_amf_pkg::wt_t                             dout
);

  localparam int NSTAGE = 2 * sls_amf_pkg::TERMS - 1;

  sls_amf_pkg::corr_t st  [NSTAGE];
  sls_amf_pkg::corr_t nxt [NSTAGE];
  logic [NSTAGE-1:0]  vld;

  logic [60:0] aprod [sls_amf_pkg::TERMS];
  logic [42:0] om_p;
  logic        vld_p;

  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb begin
        nxt[k]      = '0;
        nxt[k].y    = y;
        nxt[k].om   = om;
        nxt[k].d[0] = 34'h1_0000_0000 + 34'(sls_amf_pkg::half27(y[0]));
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else begin
          vld[k] <= in_valid;
        end
      end
    end else begin : g_rest
      localparam int J = (k + 1) / 2;
      if (k % 2 == 1) begin : g_mul
        always_comb begin
          logic [60:0] da;
          logic [60:0] ya;
          nxt[k]  = st[k-1];
          da      = 61'(st[k-1].d[J-1] - 34'h0_8000_0000);
          ya      = 61'(st[k-1].y[J-1]);
          nxt[k].prod = da * ya;
        end
      end else begin : g_add
        always_comb begin
          logic [61:0] r;
          nxt[k]      = st[k-1];
          r           = {1'b0, st[k-1].prod} + 62'h8000_0000;
          nxt[k].d[J] = st[k-1].d[J-1] + 34'(r[61:32])
                      + 34'(sls_amf_pkg::half27(st[k-1].y[J]));
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else begin
          vld[k] <= vld[k-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      st[k] <= nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sls_amf_pkg::TERMS; i++) begin
      aprod[i] <= 61'(st[NSTAGE-1].d[i]) * 61'(st[NSTAGE-1].y[i]);
    end
    om_p <= st[NSTAGE-1].om;
  end

  always_ff @(posedge clk) begin
    logic [61:0] r;
    for (int i = 0; i < sls_amf_pkg::TERMS; i++) begin
      r         = {1'b0, aprod[i]} + 62'h8000_0000;
      dout.a[i] <= r[59:32];
    end
    dout.om <= om_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_p     <= vld[NSTAGE-1];
      out_valid <= vld_p;
    end
  end

endmodule

// ===== hdl/sls_attenuation_modulus_factor_top.sv =====
// Top level of the five-mechanism standard linear solid modulus factor pipeline.
//
// One transfer is accepted in every clock cycle (busy stays low), and each one
// produces exactly one result, flagged by done for a single cycle; the receiver
// cannot stall, so results leave in input order with no holding stage. Most of
// the pipeline depth comes from the row of 27 quotient cells that form the
// scaled weights, the nine-stage corrector chain, and the row of 32 quotient
// cells that form the frequency response ratios.
module sls_attenuation_modulus_factor_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sls_amf_pkg::in_t    operand,
  output logic                done,
  output sls_amf_pkg::out_t   result
);

  localparam int T = sls_amf_pkg::TERMS;

  // Input and first multiply stages.
  logic        v1, v2;
  logic [22:0] f1;
  logic [23:0] q1;
  logic [50:0] den2;
  logic [40:0] ph2, pl2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    f1   <= operand.frequency;
    q1   <= (operand.quality_factor < sls_amf_pkg::Q_MIN) ?
            sls_amf_pkg::Q_MIN : operand.quality_factor;
    den2 <= 51'(q1) * 51'(sls_amf_pkg::DEN_SCALE);
    ph2  <= 41'(f1) * 41'(sls_amf_pkg::OM_SCALE[35:18]);
    pl2  <= 41'(f1) * 41'(sls_amf_pkg::OM_SCALE[17:0]);
  end

  // Weight division row.
  sls_amf_pkg::ydiv_t yd [sls_amf_pkg::YQ_STEPS+1];
  logic               yv [sls_amf_pkg::YQ_STEPS+1];

  always_comb begin
    logic [60:0] num;
    logic [58:0] omf;
    yd[0]     = '0;
    yd[0].den = den2;
    for (int i = 0; i < T; i++) begin
      num          = {1'b0, sls_amf_pkg::WEIGHT_NUM[i], 40'b0} + 61'(den2 >> 1);
      yd[0].rem[i] = 51'(num >> 27);
      yd[0].low[i] = num[26:0];
    end
    omf      = {ph2, 18'b0} + 59'(pl2) + 59'h8000;
    yd[0].om = omf[58:16];
  end

  assign yv[0] = v2;

  for (genvar k = 0; k < sls_amf_pkg::YQ_STEPS; k++) begin : g_ycell
    sls_amf_ydiv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (yv[k]),
      .din       (yd[k]),
      .out_valid (yv[k+1]),
      .dout      (yd[k+1])
    );
  end

  // Corrector chain.
  sls_amf_pkg::wt_t wt;
  logic             wv;

  sls_amf_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (yv[sls_amf_pkg::YQ_STEPS]),
    .y         (yd[sls_amf_pkg::YQ_STEPS].quo),
    .om        (yd[sls_amf_pkg::YQ_STEPS].om),
    .out_valid (wv),
    .dout      (wt)
  );

  // Normalization and denominator stages.
  logic                   n1v, n2v, n3v, n4v;
  logic [3:0]             sh1 [T];
  logic [42:0]            om1;
  logic [T-1:0][27:0]     a1, a2, a3, a4;
  logic [30:0]            o2 [T];
  logic [30:0]            w2 [T];
  logic [61:0]            oo3 [T];
  logic [61:0]            ov3 [T];
  logic [61:0]            vv3 [T];
  logic [61:0]            oo4 [T];
  logic [61:0]            ov4 [T];
  logic [62:0]            dd4 [T];

  always_ff @(posedge clk) begin
    if (rst) begin
      n1v <= 1'b0;
      n2v <= 1'b0;
      n3v <= 1'b0;
      n4v <= 1'b0;
    end else begin
      n1v <= wv;
      n2v <= n1v;
      n3v <= n2v;
      n4v <= n3v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < T; i++) begin
      sh1[i] <= sls_amf_pkg::norm_shift({1'b0, wt.om} | sls_amf_pkg::RATE[i]);
      o2[i]  <= 31'(om1 >> sh1[i]);
      w2[i]  <= 31'(sls_amf_pkg::RATE[i] >> sh1[i]);
      oo3[i] <= 62'(o2[i]) * 62'(o2[i]);
      ov3[i] <= 62'(o2[i]) * 62'(w2[i]);
      vv3[i] <= 62'(w2[i]) * 62'(w2[i]);
      oo4[i] <= oo3[i];
      ov4[i] <= ov3[i];
      dd4[i] <= 63'(oo3[i]) + 63'(vv3[i]);
    end
    om1 <= wt.om;
    a1  <= wt.a;
    a2  <= a1;
    a3  <= a2;
    a4  <= a3;
  end

  // Ratio division row; the integer quotient bit is resolved before the row.
  sls_amf_pkg::rdiv_t rd [sls_amf_pkg::RQ_STEPS+1];
  logic               rv [sls_amf_pkg::RQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else begin
      rv[0] <= n4v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < T; i++) begin
      rd[0].den[i] <= dd4[i];
      if ({1'b0, oo4[i]} >= dd4[i]) begin
        rd[0].rem_re[i] <= {1'b0, oo4[i]} - dd4[i];
        rd[0].q_re[i]   <= 33'd1;
      end else begin
        rd[0].rem_re[i] <= {1'b0, oo4[i]};
        rd[0].q_re[i]   <= 33'd0;
      end
      if ({1'b0, ov4[i]} >= dd4[i]) begin
        rd[0].rem_im[i] <= {1'b0, ov4[i]} - dd4[i];
        rd[0].q_im[i]   <= 33'd1;
      end else begin
        rd[0].rem_im[i] <= {1'b0, ov4[i]};
        rd[0].q_im[i]   <= 33'd0;
      end
    end
    rd[0].a <= a4;
  end

  for (genvar k = 0; k < sls_amf_pkg::RQ_STEPS; k++) begin : g_rcell
    sls_amf_rdiv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rv[k]),
      .din       (rd[k]),
      .out_valid (rv[k+1]),
      .dout      (rd[k+1])
    );
  end

  // Term products, rounding sum and saturation.
  logic        p1v, p2v;
  logic [60:0] pre [T];
  logic [60:0] pim [T];
  logic [32:0] sre, sim;
  logic [32:0] sre_next, sim_next;

  always_ff @(posedge clk) begin
    for (int i = 0; i < T; i++) begin
      pre[i] <= 61'(rd[sls_amf_pkg::RQ_STEPS].a[i])
              * 61'(rd[sls_amf_pkg::RQ_STEPS].q_re[i]);
      pim[i] <= 61'(rd[sls_amf_pkg::RQ_STEPS].a[i])
              * 61'(rd[sls_amf_pkg::RQ_STEPS].q_im[i]);
    end
  end

  always_comb begin
    logic [61:0] r;
    sre_next = 33'h0_4000_0000;
    sim_next = '0;
    for (int i = 0; i < T; i++) begin
      r        = {1'b0, pre[i]} + 62'h2_0000_0000;
      sre_next = sre_next + 33'(r[61:34]);
      r        = {1'b0, pim[i]} + 62'h2_0000_0000;
      sim_next = sim_next + 33'(r[61:34]);
    end
  end

  always_ff @(posedge clk) begin
    sre <= sre_next;
    sim <= sim_next;
    result.factor_real <= (sre > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(sre[31:0]);
    result.factor_imag <= (sim > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(sim[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v  <= 1'b0;
      p2v  <= 1'b0;
      done <= 1'b0;
    end else begin
      p1v  <= rv[sls_amf_pkg::RQ_STEPS];
      p2v  <= p1v;
      done <= p2v;
    end
  end

endmodule

// ===== sim/tb_modulus_checker.sv =====
// Checker for the modulus factor pipeline: predicts each result and compares it.
module tb_modulus_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  sls_amf_pkg::in_t  operand,
  input  logic              done,
  input  sls_amf_pkg::out_t result,
  output int                fail_count,
  output int                pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTERM = 5;
  localparam longint unsigned WNUM [NTERM] = '{
    64'd969880, 64'd832481, 64'd887440, 64'd735887, 64'd866749
  };
  localparam longint unsigned WRATE [NTERM] = '{
    64'd471238898, 64'd6633708850, 64'd94247779600,
    64'd1146724360000, 64'd10559707900000
  };

  sls_amf_pkg::out_t modulus_queue [$];

  // Bit-serial floor(num * 2^32 / den).
  function automatic longint unsigned ratio_quotient(longint unsigned num,
                                                     longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = num;
    if (r >= den) begin
      q = 1;
      r = r - den;
    end
    for (int k = 0; k < 32; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic sls_amf_pkg::out_t modulus_factor(sls_amf_pkg::in_t op);
    longint unsigned f, qr, den, om, m, o, v, dd;
    longint unsigned y [NTERM];
    longint unsigned d [NTERM];
    longint unsigned a [NTERM];
    longint re, im;
    int s;
    sls_amf_pkg::out_t res;
    f = 64'(op.frequency);
    qr = 64'(op.quality_factor);
    re = 64'sd1 << 30;
    im = 0;
    if (qr < 256) qr = 256;
    den = 64'd100000000 * qr;
    for (int i = 0; i < NTERM; i++) y[i] = ((WNUM[i] << 40) + (den >> 1)) / den;
    d[0] = (64'd1 << 32) + ((y[0] + 1) >> 1);
    for (int i = 1; i < NTERM; i++)
      d[i] = d[i-1] + (((d[i-1] - (64'd1 << 31)) * y[i-1] + (64'd1 << 31)) >> 32)
             + ((y[i] + 1) >> 1);
    for (int i = 0; i < NTERM; i++) a[i] = (d[i] * y[i] + (64'd1 << 31)) >> 32;
    om = (f * 64'd62831853072 + (64'd1 << 15)) >> 16;
    for (int i = 0; i < NTERM; i++) begin
      m = om | WRATE[i];
      s = 0;
      while ((m >> s) >= (64'd1 << 31)) s++;
      o = om >> s;
      v = WRATE[i] >> s;
      dd = o * o + v * v;
      if (dd != 0) begin
        re += longint'((a[i] * ratio_quotient(o * o, dd) + (64'd1 << 33)) >> 34);
        im += longint'((a[i] * ratio_quotient(o * v, dd) + (64'd1 << 33)) >> 34);
      end
    end
    if (re > 64'sd2147483647) re = 64'sd2147483647;
    if (im > 64'sd2147483647) im = 64'sd2147483647;
    res.factor_real = re[31:0];
    res.factor_imag = im[31:0];
    return res;
  endfunction

  assign pending_count = modulus_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
      modulus_queue.delete();
    end else begin
      sls_amf_pkg::out_t want;
      int errs;
      errs = 0;
      if (done) begin
        if (modulus_queue.size() == 0) begin
          $error("result with no transfer waiting: %h", result);
          errs++;
        end else begin
          want = modulus_queue.pop_front();
          if (result.factor_real !== want.factor_real) begin
            $error("factor_real expected %h actual %h", want.factor_real,
                   result.factor_real);
            errs++;
          end
          if (result.factor_imag !== want.factor_imag) begin
            $error("factor_imag expected %h actual %h", want.factor_imag,
                   result.factor_imag);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (start && !busy) modulus_queue.push_back(modulus_factor(operand));
    end
  end
endmodule

// ===== sim/tb.sv =====
// Stimulus and verdict for the modulus factor pipeline testbench.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  sls_amf_pkg::in_t operand = '0;
  sls_amf_pkg::out_t result;
  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int idle_pct = 0;
  int sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sls_attenuation_modulus_factor_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand(operand), .done(done), .result(result)
  );

  tb_modulus_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operand(operand),
    .done(done), .result(result), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // One transfer; random idle cycles precede it, and start holds across
  // back-to-back transfers.
  task automatic send_item(logic [22:0] f, logic [23:0] q);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    operand <= '{frequency: f, quality_factor: q};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [22:0] rand_freq();
    case ($urandom_range(3))
      0: return 23'($urandom_range(6553600));
      1: return 23'($urandom_range(65536));
      2: return 23'($urandom_range(655));
      default: return 23'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_q();
    case ($urandom_range(3))
      0: return 24'($urandom_range(256, 25600));
      1: return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [22:0] dir_f [8];
    logic [23:0] dir_q [5];
    dir_f = '{23'd0, 23'd1, 23'd655, 23'd65536, 23'd6553600, 23'h7fffff,
              23'h555555, 23'h2aaaaa};
    dir_q = '{24'd0, 24'd255, 24'd256, 24'hffffff, 24'd2560};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Corners: zero frequency, Q below one, largest fields, alternating bits.
    for (int i = 0; i < 8; i++) send_item(dir_f[i], dir_q[i % 5]);
    for (int i = 0; i < 5; i++) send_item(23'd65536, dir_q[i]);
    send_item(23'h555555, 24'haaaaaa);
    send_item(23'h2aaaaa, 24'h555555);
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 33 : ((phase == 1) ? 60 : 0);
      for (int n = 0; n < 200; n++) send_item(rand_freq(), rand_q());
    end
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d transfers: frequency and Q corners, Q below one, random grids,", sent);
    $display("with light then heavy sender gaps, then back-to-back.");
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/sls_amf_pkg.sv
hdl/sls_amf_ydiv_cell.sv
hdl/sls_amf_rdiv_cell.sv
hdl/sls_amf_corr.sv
hdl/sls_attenuation_modulus_factor_top.sv
sim/tb_modulus_checker.sv
sim/tb.sv
